// ===== hw/rtl/shash_pkg.sv =====
// ----------------------------------------------------------------------------
// shash_pkg
// Shared types, constants and tables for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shash_pkg;

  localparam int DIGEST_WORDS = 8;
  localparam int BLOCK_BYTES  = 64;
  localparam int ROUNDS       = 64;
  localparam int LEN_POS      = 56;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  // kind of block being compressed
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD,
    BLK_LEN,
    BLK_FINAL
  } blk_t;

  typedef struct packed {
    logic [2:0]  rd_addr;
    logic        wr_en;
    logic [2:0]  wr_addr;
    logic [31:0] wr_data;
    logic        clr;
  } chain_req_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] w;
    unique case (idx)
      3'd0: w = 32'h6a09e667;
      3'd1: w = 32'hbb67ae85;
      3'd2: w = 32'h3c6ef372;
      3'd3: w = 32'ha54ff53a;
      3'd4: w = 32'h510e527f;
      3'd5: w = 32'h9b05688c;
      3'd6: w = 32'h1f83d9ab;
      3'd7: w = 32'h5be0cd19;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, one byte per input beat.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with in_func and in_data_byte. A beat with
// in_func low appends in_data_byte to the 64-byte block buffer; the 64th byte
// starts a compression. A beat with in_func high pads the message, runs one
// or two final compressions and then sends the digest.
// Output channel: out_valid/out_ready, eight beats of out_digest_word with
// out_word_index 0..7 (most significant first), out_last on index 7.
// Flow: absorb beats are taken while the block is idle; a full block then
// holds in_ready low while the buffer is read into the schedule window, the
// rounds run and the results are added back into the chaining memory. A
// finish takes one or two compressions, then reads each digest word through
// the single chaining memory read port, and waits on receiver stalls.
// in_ready is low during each compression and, after a finish, until the
// last digest beat is taken; a stalled receiver simply holds the block in
// its output phase. After the digest the block is back in its reset state.
// Reset: chaining words read as the IV, fill count and bit length clear.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last
);

  localparam logic [6:0] LOAD_END  = 7'(shash_pkg::BLOCK_BYTES);
  localparam logic [6:0] ROUND_END = 7'(shash_pkg::ROUNDS - 1);
  localparam logic [6:0] FOLD_END  = 7'(shash_pkg::DIGEST_WORDS);
  localparam logic [5:0] LEN_START = 6'(shash_pkg::LEN_POS);
  localparam logic [5:0] FILL_LAST = 6'(shash_pkg::BLOCK_BYTES - 1);
  localparam logic [2:0] LAST_IDX  = 3'(shash_pkg::DIGEST_WORDS - 1);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
    return (x >> r) | (x << (32 - r));
  endfunction

  shash_pkg::state_t state_r, state_nxt;
  shash_pkg::blk_t   blk_r, blk_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  msg_bits_r, msg_bits_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [511:0] win_r, win_nxt;
  logic [31:0]  v_r [8];
  logic [31:0]  v_nxt [8];
  logic [2:0]   emit_idx_r, emit_idx_nxt;
  logic         rd_pend_r, rd_pend_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_word_r, out_word_nxt;
  logic [5:0]   ld_idx_r;
  logic [7:0]   buf_q_r;
  logic [7:0]   buf_mem [shash_pkg::BLOCK_BYTES];

  shash_pkg::chain_req_t chain_req;
  logic [31:0] chain_rd;

  logic        in_acc, out_acc;
  logic [7:0]  ld_byte, len_byte;
  logic [2:0]  len_sel;
  logic [31:0] w0, wnew, t1, t2, s1e, s0a, ch, maj;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid_r & out_ready;

  assign in_ready        = (state_r == shash_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = emit_idx_r;
  assign out_last        = (emit_idx_r == LAST_IDX);

  shash_chain_mem u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (chain_req),
    .rd_data (chain_rd)
  );

  // block buffer
  always_ff @(posedge clk) begin
    if (in_acc && !in_func) begin
      buf_mem[fill_r] <= in_data_byte;
    end
    buf_q_r  <= buf_mem[cnt_r[5:0]];
    ld_idx_r <= cnt_r[5:0];
  end

  // padding and length bytes are generated on the fly
  assign len_sel  = ~ld_idx_r[2:0];
  assign len_byte = len_r[{len_sel, 3'b000} +: 8];

  always_comb begin
    ld_byte = 8'h00;
    unique case (blk_r)
      shash_pkg::BLK_DATA: ld_byte = buf_q_r;
      shash_pkg::BLK_PAD: begin
        priority if (ld_idx_r < fill_r) ld_byte = buf_q_r;
        else if (ld_idx_r == fill_r)    ld_byte = shash_pkg::PAD_BYTE;
        else                            ld_byte = 8'h00;
      end
      shash_pkg::BLK_FINAL: begin
        priority if (ld_idx_r < fill_r) ld_byte = buf_q_r;
        else if (ld_idx_r == fill_r)    ld_byte = shash_pkg::PAD_BYTE;
        else if (ld_idx_r >= LEN_START) ld_byte = len_byte;
        else                            ld_byte = 8'h00;
      end
      shash_pkg::BLK_LEN: ld_byte = (ld_idx_r >= LEN_START) ? len_byte : 8'h00;
      default: ld_byte = 8'h00;
    endcase
  end

  // round function and schedule
  assign w0   = win_r[511:480];
  assign s1e  = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign s0a  = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1   = v_r[7] + s1e + ch + shash_pkg::round_const(cnt_r[5:0]) + w0;
  assign t2   = s0a + maj;
  assign wnew = (rotr(win_r[63:32], 17) ^ rotr(win_r[63:32], 19) ^ (win_r[63:32] >> 10))
              + win_r[223:192]
              + (rotr(win_r[479:448], 7) ^ rotr(win_r[479:448], 18) ^ (win_r[479:448] >> 3))
              + w0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shash_pkg::S_IDLE: begin
        if (in_acc && (in_func || fill_r == FILL_LAST)) begin
          state_nxt = shash_pkg::S_LOAD;
        end
      end
      shash_pkg::S_LOAD: begin
        if (cnt_r == LOAD_END) state_nxt = shash_pkg::S_ROUND;
      end
      shash_pkg::S_ROUND: begin
        if (cnt_r == ROUND_END) state_nxt = shash_pkg::S_FOLD;
      end
      shash_pkg::S_FOLD: begin
        if (cnt_r == FOLD_END) begin
          unique case (blk_r)
            shash_pkg::BLK_DATA: state_nxt = shash_pkg::S_IDLE;
            shash_pkg::BLK_PAD:  state_nxt = shash_pkg::S_LOAD;
            default:             state_nxt = shash_pkg::S_EMIT;
          endcase
        end
      end
      shash_pkg::S_EMIT: begin
        if (out_acc && emit_idx_r == LAST_IDX) state_nxt = shash_pkg::S_IDLE;
      end
      default: state_nxt = shash_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    blk_nxt       = blk_r;
    fill_nxt      = fill_r;
    msg_bits_nxt  = msg_bits_r;
    len_nxt       = len_r;
    win_nxt       = win_r;
    v_nxt         = v_r;
    emit_idx_nxt  = emit_idx_r;
    rd_pend_nxt   = rd_pend_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    chain_req     = '0;
    cnt_nxt       = '0;
    if (state_nxt == state_r && state_r != shash_pkg::S_IDLE
        && state_r != shash_pkg::S_EMIT) begin
      cnt_nxt = cnt_r + 7'd1;
    end

    unique case (state_r)
      shash_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_func) begin
            len_nxt = msg_bits_r + {55'd0, fill_r, 3'b000};
            blk_nxt = (fill_r >= LEN_START) ? shash_pkg::BLK_PAD : shash_pkg::BLK_FINAL;
          end else begin
            fill_nxt = fill_r + 6'd1;
            if (fill_r == FILL_LAST) begin
              blk_nxt      = shash_pkg::BLK_DATA;
              msg_bits_nxt = msg_bits_r + shash_pkg::BLOCK_BITS;
            end
          end
        end
      end
      shash_pkg::S_LOAD: begin
        chain_req.rd_addr = cnt_r[2:0];
        if (cnt_r != 7'd0) begin
          win_nxt = {win_r[503:0], ld_byte};
        end
        if (cnt_r != 7'd0 && cnt_r <= FOLD_END) begin
          for (int k = 0; k < 7; k++) v_nxt[k] = v_r[k+1];
          v_nxt[7] = chain_rd;
        end
      end
      shash_pkg::S_ROUND: begin
        win_nxt  = {win_r[479:0], wnew};
        v_nxt[0] = t1 + t2;
        v_nxt[1] = v_r[0];
        v_nxt[2] = v_r[1];
        v_nxt[3] = v_r[2];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[5] = v_r[4];
        v_nxt[6] = v_r[5];
        v_nxt[7] = v_r[6];
      end
      shash_pkg::S_FOLD: begin
        chain_req.rd_addr = cnt_r[2:0];
        if (cnt_r != 7'd0) begin
          chain_req.wr_en   = 1'b1;
          chain_req.wr_addr = cnt_r[2:0] - 3'd1;
          chain_req.wr_data = chain_rd + v_r[0];
          for (int k = 0; k < 7; k++) v_nxt[k] = v_r[k+1];
          v_nxt[7] = v_r[0];
        end
        if (cnt_r == FOLD_END && blk_r == shash_pkg::BLK_PAD) begin
          blk_nxt = shash_pkg::BLK_LEN;
        end
      end
      shash_pkg::S_EMIT: begin
        chain_req.rd_addr = emit_idx_r;
        if (!out_valid_r && !rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          rd_pend_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain_rd;
        end
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          emit_idx_nxt  = emit_idx_r + 3'd1;
          if (emit_idx_r == LAST_IDX) begin
            chain_req.clr = 1'b1;
            fill_nxt      = '0;
            msg_bits_nxt  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shash_pkg::S_IDLE;
      blk_r       <= shash_pkg::BLK_DATA;
      cnt_r       <= '0;
      fill_r      <= '0;
      msg_bits_r  <= '0;
      emit_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blk_r       <= blk_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      msg_bits_r  <= msg_bits_nxt;
      emit_idx_r  <= emit_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    win_r      <= win_nxt;
    v_r        <= v_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// ===== hw/rtl/shash_chain_mem.sv =====
// ----------------------------------------------------------------------------
// shash_chain_mem
// Eight-word chaining memory, one read and one write port, registered read.
// Per-entry valid bits make an unwritten or cleared entry read as the IV.
// ----------------------------------------------------------------------------
module shash_chain_mem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  shash_pkg::chain_req_t  req,
  output logic [31:0]            rd_data
);

  logic [31:0] mem [shash_pkg::DIGEST_WORDS];
  logic [shash_pkg::DIGEST_WORDS-1:0] vld_r;
  logic [31:0] q_r;
  logic        qv_r;
  logic [2:0]  qa_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    q_r  <= mem[req.rd_addr];
    qa_r <= req.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      qv_r <= vld_r[req.rd_addr];
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = qv_r ? q_r : shash_pkg::iv_word(qa_r);

endmodule

// ===== hw/rtl/shash_checker.sv =====
// ----------------------------------------------------------------------------
// shash_checker
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module shash_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last
);

  // a stalled digest beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("digest beat changed under stall");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_word_index == 3'd7)))
    else $error("last flag does not match word index");

  // no input taken while the digest is going out
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready during digest output");

  a_mid_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("block went idle before the last digest word");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sha256_stream_hasher shash_checker u_shash_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last        (out_last)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher testbench
// Streams byte messages of assorted lengths through the hasher, padding edge
// lengths included, and checks each digest beat against a behavioral SHA-256
// kept in a scoreboard class. Sender gaps, receiver stalls and one long
// receiver hold-off each get a phase; a last phase mixes gaps and stalls.
// ----------------------------------------------------------------------------
package hasher_tb_pkg;

  typedef enum bit {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } hash_op_t;

  localparam bit [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    bit [31:0] word;
    bit [2:0]  index;
    bit        last;
  } digest_beat_t;

  class digest_scoreboard;
    bit [31:0]    chain [8];
    bit [7:0]     block_bytes [64];
    int unsigned  fill;
    bit [63:0]    bit_length;
    digest_beat_t digest_q [$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
      fill = 0;
      bit_length = 64'd0;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int r);
      return (x >> r) | (x << (32 - r));
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2, ch, maj;
      for (int t = 0; t < 16; t++)
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
        s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
        s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
        s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1  = v[7] + s1 + ch + ROUND_K[t] + w[t];
        t2  = s0 + maj;
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function void note_beat(hash_op_t op, bit [7:0] data);
      int unsigned pos;
      digest_beat_t beat;
      if (op == OP_ABSORB) begin
        block_bytes[fill] = data;
        fill = (fill + 1) % 64;
        if (fill == 0) begin
          compress();
          bit_length = bit_length + 64'd512;
        end
        return;
      end
      pos = fill;
      block_bytes[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          block_bytes[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      bit_length = bit_length + 64'(fill) * 64'd8;
      for (int j = 0; j < 8; j++) block_bytes[63-j] = bit_length[8*j +: 8];
      compress();
      for (int j = 0; j < 8; j++) begin
        beat.word  = chain[j];
        beat.index = 3'(j);
        beat.last  = (j == 7);
        digest_q = {digest_q, beat};
      end
      restart();
    endfunction

    function void check_word(bit [31:0] word, bit [2:0] index, bit last);
      digest_beat_t exp_beat;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat word=%h index=%0d last=%0b",
                 $time, word, index, last);
        errors++;
        return;
      end
      exp_beat = digest_q.pop_front();
      if (word !== exp_beat.word) begin
        $display("%0t: digest_word mismatch expected %h actual %h", $time, exp_beat.word, word);
        errors++;
      end
      if (index !== exp_beat.index) begin
        $display("%0t: word_index mismatch expected %0d actual %0d", $time, exp_beat.index, index);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: last mismatch expected %0b actual %0b", $time, exp_beat.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

endpackage

module testbench;
  import hasher_tb_pkg::*;

  localparam int LONG_HOLD   = 900;
  localparam int PHASE_BEATS = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last;

  digest_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_sent = 0;
  int hold_requests = 0;
  int holds_taken = 0;
  int hold_left = 0;

  sha256_stream_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last        (out_last)
  );

  always #4 clk = ~clk;

  // receiver side
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_digest_word, out_word_index, out_last);
    if (hold_requests != holds_taken) begin
      holds_taken++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // valid stays high after acceptance; lowered only on a gap or in drain_digests
  task automatic send_beat(hash_op_t op, bit [7:0] data);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_func      <= op;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(op, data);
    beats_sent++;
  endtask

  task automatic hash_message(int len, bit hold_output);
    for (int i = 0; i < len; i++) send_beat(OP_ABSORB, 8'($urandom_range(0, 255)));
    if (hold_output) hold_requests++;
    send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 8);
    if (r < 7) begin
      case ($urandom_range(0, 7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        default: return 120;
      endcase
    end
    return $urandom_range(0, 70);
  endfunction

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, then finish with a nonzero data byte that must be ignored
    send_beat(OP_FINISH, 8'h00);
    send_beat(OP_FINISH, 8'hff);
    send_beat(OP_ABSORB, 8'h61);
    send_beat(OP_ABSORB, 8'h62);
    send_beat(OP_ABSORB, 8'h63);
    send_beat(OP_FINISH, 8'h00);
    send_beat(OP_ABSORB, 8'h00);
    send_beat(OP_ABSORB, 8'hff);
    send_beat(OP_ABSORB, 8'h80);
    send_beat(OP_ABSORB, 8'h7f);
    send_beat(OP_FINISH, 8'haa);
    drain_digests();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      beats_sent = 0;
      // long output hold-off with the next message already waiting at the input
      if (phase == 0) begin
        hash_message(pick_length(), 1'b1);
        hash_message(pick_length(), 1'b0);
      end
      while (beats_sent < PHASE_BEATS) hash_message(pick_length(), 1'b0);
      drain_digests();
    end

    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS sha256_stream_hasher");
    end else begin
      $display("FAIL sha256_stream_hasher");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL sha256_stream_hasher");
    $finish;
  end

endmodule
